@@ sv/lpht_pkg.sv @@
package lpht_pkg;

  // table geometry
  localparam int MAX_SLOTS  = 32;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;

  // field widths
  localparam int SIZE_W     = 6;
  localparam int KEY_W      = 31;
  localparam int REC_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 5;
  localparam int DIVCNT_W   = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                set_home;
    logic                probe_inc;
    logic                rd_en;
    logic                ins_write;
    logic                del_clear;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } lpht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic div_last;
    logic p_end;
    logic slot_valid;
    logic key_match;
  } lpht_stat_t;

endpackage

@@ sv/lpht_ram.sv @@
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lpht_dp.sv @@
module lpht_dp
  import lpht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SIZE_W-1:0]   cfg_wdata,
  input  logic                in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [REC_W-1:0]    in_record,
  input  lpht_cmd_t           cmd,
  output lpht_stat_t          stat,
  output logic [STATUS_W-1:0] res_status,
  output logic [POS_W-1:0]    res_position,
  output logic [REC_W-1:0]    res_removed
);

  localparam int EW = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [SIZE_W-1:0]   table_size;
  logic [EW-1:0]       size_w;
  logic [CNT_W-1:0]    n_eff;

  logic                op;
  logic [KEY_W-1:0]    key;
  logic [REC_W-1:0]    record;
  logic [KEY_W-1:0]    key_sh;
  logic [DIVCNT_W-1:0] div_cnt;
  logic [SLOT_W-1:0]   rem;
  logic [CNT_W-1:0]    rem_try;
  logic [SLOT_W-1:0]   home;
  logic [CNT_W-1:0]    p;
  logic [SLOT_W-1:0]   p_idx;
  logic [MAX_SLOTS-1:0] slot_valid;

  logic [KEY_W+REC_W-1:0] ram_rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [REC_W-1:0]       rd_record;

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  always_comb begin
    size_w = EW'(table_size);
    if (size_w == '0) begin
      n_eff = CNT_W'(1);
    end else if (size_w > EW'(MAX_SLOTS)) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = CNT_W'(size_w);
    end
  end

  // restoring remainder, one key bit a cycle, msb first
  assign rem_try = {rem, key_sh[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_op;
      key     <= in_key;
      record  <= in_record;
      key_sh  <= in_key;
      div_cnt <= '0;
      rem     <= '0;
    end else if (cmd.div_step) begin
      key_sh  <= key_sh << 1;
      div_cnt <= div_cnt + DIVCNT_W'(1);
      if (rem_try >= n_eff) begin
        rem <= SLOT_W'(rem_try - n_eff);
      end else begin
        rem <= SLOT_W'(rem_try);
      end
    end
  end

  // probe pointer
  always_ff @(posedge clk) begin
    if (cmd.set_home) begin
      home <= rem;
      p    <= CNT_W'(rem);
    end else if (cmd.probe_inc) begin
      p    <= p + CNT_W'(1);
    end
  end

  assign p_idx = p[SLOT_W-1:0];

  // occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.ins_write) begin
      slot_valid[p_idx] <= 1'b1;
    end else if (cmd.del_clear) begin
      slot_valid[p_idx] <= 1'b0;
    end
  end

  // key and record store
  lpht_ram #(
    .WIDTH (KEY_W + REC_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (p_idx),
    .wdata ({key, record}),
    .re    (cmd.rd_en),
    .raddr (p_idx),
    .rdata (ram_rdata)
  );

  assign rd_key    = ram_rdata[KEY_W+REC_W-1:REC_W];
  assign rd_record = ram_rdata[REC_W-1:0];

  always_comb begin
    stat.op         = op;
    stat.div_last   = (div_cnt == DIVCNT_W'(KEY_W - 1));
    stat.p_end      = (p >= n_eff);
    stat.slot_valid = slot_valid[p_idx];
    stat.key_match  = (rd_key == key);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      if (cmd.res_status == ST_DONE) begin
        res_position <= POS_W'(p);
      end else begin
        res_position <= POS_W'(home);
      end
      if (cmd.res_status == ST_DONE && op == OP_DELETE) begin
        res_removed <= rd_record;
      end else begin
        res_removed <= '0;
      end
    end
  end

endmodule

@@ sv/lpht_ctrl.sv @@
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lpht_stat_t stat,
  output lpht_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_HOME  = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_DHOME = 3'd4;
  localparam logic [2:0] S_DRD   = 3'd5;
  localparam logic [2:0] S_DCMP  = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0]          state, state_next;
  logic [STATUS_W-1:0] res_code, res_code_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    res_code_next  = res_code;
    cmd            = '0;
    cmd.res_status = res_code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        cmd.set_home = 1'b1;
        state_next   = (stat.op == OP_DELETE) ? S_DHOME : S_INS;
      end
      S_INS: begin
        if (stat.p_end) begin
          res_code_next = ST_FULL;
          state_next    = S_RES;
        end else if (!stat.slot_valid) begin
          cmd.ins_write = 1'b1;
          res_code_next = ST_DONE;
          state_next    = S_RES;
        end else begin
          cmd.probe_inc = 1'b1;
        end
      end
      S_DHOME: begin
        if (!stat.slot_valid) begin
          res_code_next = ST_NOT_FOUND;
          state_next    = S_RES;
        end else begin
          state_next    = S_DRD;
        end
      end
      S_DRD: begin
        if (stat.p_end) begin
          res_code_next = ST_NOT_FOUND;
          state_next    = S_RES;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_DCMP;
        end
      end
      S_DCMP: begin
        if (stat.slot_valid && stat.key_match) begin
          cmd.del_clear = 1'b1;
          res_code_next = ST_DONE;
          state_next    = S_RES;
        end else begin
          cmd.probe_inc = 1'b1;
          state_next    = S_DRD;
        end
      end
      S_RES: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_code  <= ST_DONE;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/linear_probe_hash_table.sv @@
// flow: a 31-step remainder of the key picks the home slot; insert then probes upward for a free slot,
// delete reads slots from home on until a valid slot's key matches; neither walk wraps past the table's end
// one word at a time: s_tready is high only while the controller is idle
// the output register frees the controller so a new word is taken while a result waits
// reset (rst, synchronous): empty table, size register back to 32, no result pending
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // size register
  input  logic                cfg_we,
  input  logic [SIZE_W-1:0]   cfg_wdata,
  // request stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,   // key [30:0], record [62:31], zero [63]
  input  logic                s_tuser,   // op: 0 insert, 1 delete
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,   // position [4:0], removed_record [36:5], zero [39:37]
  output logic [STATUS_W-1:0] m_tuser    // status: done, not found, no free slot
);

  lpht_cmd_t           cmd;
  lpht_stat_t          stat;
  logic [STATUS_W-1:0] res_status;
  logic [POS_W-1:0]    res_position;
  logic [REC_W-1:0]    res_removed;

  // sequencer: remainder, probe walk, result handoff
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // size register, remainder unit, probe pointer, slot store, result register
  lpht_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_op        (s_tuser),
    .in_key       (s_tdata[KEY_W-1:0]),
    .in_record    (s_tdata[KEY_W+REC_W-1:KEY_W]),
    .cmd          (cmd),
    .stat         (stat),
    .res_status   (res_status),
    .res_position (res_position),
    .res_removed  (res_removed)
  );

  // pack the result word, padding to whole bytes
  assign m_tdata = {3'b000, res_removed, res_position};
  assign m_tuser = res_status;

endmodule
